/* hdl/arpp_pkg.sv */
package arpp_pkg;

   // Default frame store depth in bytes.
   localparam int MAX_FRAME_DEF = 2048;
   // Entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH   = 2;

   localparam int LEN_W  = 12;
   localparam int MAC_W  = 48;
   localparam int IP_W   = 32;
   localparam int CSR_W  = 48;

   // Request codes on req_type.
   localparam logic REQ_FRAME_BYTE = 1'b0;
   localparam logic REQ_READ_BYTE  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_OWN_MAC = 1'b0;
   localparam logic CSR_OWN_IP  = 1'b1;

   // Protocol constants.
   localparam logic [15:0] ETHERTYPE_ARP     = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [15:0] ARP_OP_REQUEST    = 16'h0001;
   localparam logic [7:0]  IP_PROTO_ICMP     = 8'h01;
   localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'h08;
   localparam logic [3:0]  IHL_MIN           = 4'd5;
   localparam int          ETH_HDR_LEN       = 14;
   localparam int          ARP_MIN_LEN       = 42;
   localparam int          ARP_REPLY_LEN     = 60;
   localparam int          ICMP_MIN_LEN      = 42;

   typedef enum logic [2:0] {
      STATUS_NONE     = 3'd0,
      STATUS_ARP      = 3'd1,
      STATUS_ECHO     = 3'd2,
      STATUS_IGNORED  = 3'd3,
      STATUS_TOO_LONG = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_ARP     = 2'd1,
      KIND_ECHO    = 2'd2,
      KIND_IGNORED = 2'd3
   } kind_type;

   // One operation handed from the front to the back.
   typedef struct packed {
      logic             mem_write;
      logic             mem_read;
      logic [7:0]       wdata;
      logic [7:0]       tx_const;
      logic             tx_last;
      status_type       status;
      logic [LEN_W-1:0] length;
   } cmd_type;

   // Fixed middle part of an ARP reply: EtherType, hardware type, protocol type,
   // address lengths and the reply opcode.
   function automatic logic [7:0] arp_fixed(input logic [3:0] k);
      logic [7:0] r;
      unique case (k)
         4'd0:    r = 8'h08;
         4'd1:    r = 8'h06;
         4'd2:    r = 8'h00;
         4'd3:    r = 8'h01;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h00;
         4'd6:    r = 8'h06;
         4'd7:    r = 8'h04;
         4'd8:    r = 8'h00;
         4'd9:    r = 8'h02;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // One's-complement add with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, s} + {1'b0, v};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

/* hdl/arpp_front.sv */
module arpp_front #(
   parameter int MAX_FRAME = arpp_pkg::MAX_FRAME_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_rx_last,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [arpp_pkg::CSR_W-1:0]    csr_write_data,
   input  logic                          queue_full,
   output logic                          push_valid,
   output arpp_pkg::cmd_type             push_cmd,
   output logic [$clog2(MAX_FRAME)-1:0]  push_addr
);
   import arpp_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);

   logic [MAC_W-1:0] own_mac_ff;
   logic [IP_W-1:0]  own_ip_ff;

   logic [CW-1:0]  wc_ff, wc_in;
   logic [CW-1:0]  ri_ff, ri_in;
   logic [CW-1:0]  plen_ff, plen_in;
   kind_type       kind_ff, kind_in;
   logic [5:0]     hb_ff, hb_in;
   logic [31:0]    ck_ff, ck_in;
   logic           ovf_ff, ovf_in;
   logic [15:0]    ipsum_ff, ipsum_in;
   logic [15:0]    icsum_ff, icsum_in;

   // Header fields captured as the frame streams in.
   logic [15:0]    etype_ff, etype_in;
   logic [15:0]    op_ff, op_in;
   logic [7:0]     proto_ff, proto_in;
   logic [3:0]     ihl_ff, ihl_in;
   logic [31:0]    ipdst_ff, ipdst_in;
   logic [31:0]    tpa_ff, tpa_in;
   logic [7:0]     ictype_ff, ictype_in;

   logic           accept;
   logic           stored;
   logic [6:0]     hdr_end;
   logic [15:0]    word;
   logic [CW-1:0]  ic;
   logic           rd_mem;
   logic [CW-1:0]  rd_addr;
   logic [7:0]     rd_const;
   logic [2:0]     mac_k;
   logic [1:0]     ip_k;
   status_type     status;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   function automatic logic [7:0] mac_sel(input logic [MAC_W-1:0] m, input logic [2:0] k);
      logic [7:0] r;
      unique case (k)
         3'd0:    r = m[47:40];
         3'd1:    r = m[39:32];
         3'd2:    r = m[31:24];
         3'd3:    r = m[23:16];
         3'd4:    r = m[15:8];
         default: r = m[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ip_sel(input logic [IP_W-1:0] a, input logic [1:0] k);
      logic [7:0] r;
      unique case (k)
         2'd0:    r = a[31:24];
         2'd1:    r = a[23:16];
         2'd2:    r = a[15:8];
         default: r = a[7:0];
      endcase
      return r;
   endfunction

   // Source of the reply byte at the current read index.
   always_comb begin
      ic       = CW'(ETH_HDR_LEN) + CW'(hb_ff);
      rd_mem   = 1'b0;
      rd_addr  = ri_ff;
      rd_const = 8'h00;
      mac_k    = 3'd0;
      ip_k     = 2'd0;
      if (kind_ff == KIND_ARP) begin
         if (ri_ff < CW'(6)) begin
            rd_mem  = 1'b1;
            rd_addr = ri_ff + CW'(22);
         end else if (ri_ff < CW'(12)) begin
            mac_k    = 3'(ri_ff - CW'(6));
            rd_const = mac_sel(own_mac_ff, mac_k);
         end else if (ri_ff < CW'(22)) begin
            rd_const = arp_fixed(4'(ri_ff - CW'(12)));
         end else if (ri_ff < CW'(28)) begin
            mac_k    = 3'(ri_ff - CW'(22));
            rd_const = mac_sel(own_mac_ff, mac_k);
         end else if (ri_ff < CW'(32)) begin
            ip_k     = 2'(ri_ff - CW'(28));
            rd_const = ip_sel(own_ip_ff, ip_k);
         end else if (ri_ff < CW'(ARP_MIN_LEN)) begin
            rd_mem  = 1'b1;
            rd_addr = ri_ff - CW'(10);
         end
      end else begin
         if (ri_ff == CW'(24)) begin
            rd_const = ck_ff[31:24];
         end else if (ri_ff == CW'(25)) begin
            rd_const = ck_ff[23:16];
         end else if (ri_ff == ic + CW'(2)) begin
            rd_const = ck_ff[15:8];
         end else if (ri_ff == ic + CW'(3)) begin
            rd_const = ck_ff[7:0];
         end else if (ri_ff < CW'(6)) begin
            rd_mem  = 1'b1;
            rd_addr = ri_ff + CW'(6);
         end else if (ri_ff < CW'(12)) begin
            mac_k    = 3'(ri_ff - CW'(6));
            rd_const = mac_sel(own_mac_ff, mac_k);
         end else if (ri_ff >= CW'(26) && ri_ff < CW'(30)) begin
            ip_k     = 2'(ri_ff - CW'(26));
            rd_const = ip_sel(own_ip_ff, ip_k);
         end else if (ri_ff >= CW'(30) && ri_ff < CW'(34)) begin
            rd_mem  = 1'b1;
            rd_addr = ri_ff - CW'(4);
         end else if (ri_ff != ic) begin
            rd_mem = 1'b1;
         end
      end
   end

   always_comb begin
      wc_in     = wc_ff;
      ri_in     = ri_ff;
      plen_in   = plen_ff;
      kind_in   = kind_ff;
      hb_in     = hb_ff;
      ck_in     = ck_ff;
      ovf_in    = ovf_ff;
      ipsum_in  = ipsum_ff;
      icsum_in  = icsum_ff;
      etype_in  = etype_ff;
      op_in     = op_ff;
      proto_in  = proto_ff;
      ihl_in    = ihl_ff;
      ipdst_in  = ipdst_ff;
      tpa_in    = tpa_ff;
      ictype_in = ictype_ff;
      push_valid = 1'b0;
      push_cmd   = '0;
      push_addr  = '0;
      stored     = wc_ff < CW'(MAX_FRAME);
      word       = wc_ff[0] ? {8'h00, req_rx_byte} : {req_rx_byte, 8'h00};
      hdr_end    = 7'd0;
      status     = STATUS_NONE;
      if (accept) begin
         push_valid = 1'b1;
         if (req_type == REQ_FRAME_BYTE) begin
            // The first byte of a frame drops whatever was pending.
            if (wc_ff == '0) begin
               kind_in  = KIND_NONE;
               plen_in  = '0;
               ri_in    = '0;
               ovf_in   = 1'b0;
               ipsum_in = '0;
               icsum_in = '0;
            end
            if (stored) begin
               wc_in              = wc_ff + CW'(1);
               push_cmd.mem_write = 1'b1;
               push_cmd.wdata     = req_rx_byte;
               push_addr          = wc_ff[AW-1:0];
               if (wc_ff == CW'(12) || wc_ff == CW'(13)) etype_in = {etype_ff[7:0], req_rx_byte};
               if (wc_ff == CW'(20) || wc_ff == CW'(21)) op_in = {op_ff[7:0], req_rx_byte};
               if (wc_ff == CW'(23)) proto_in = req_rx_byte;
               if (wc_ff == CW'(14)) ihl_in = req_rx_byte[3:0];
               if (wc_ff >= CW'(30) && wc_ff < CW'(34)) ipdst_in = {ipdst_ff[23:0], req_rx_byte};
               if (wc_ff >= CW'(38) && wc_ff < CW'(42)) tpa_in = {tpa_ff[23:0], req_rx_byte};
               hdr_end = 7'(ETH_HDR_LEN) + {1'b0, ihl_in, 2'b00};
               if (wc_ff == CW'(hdr_end) && wc_ff > CW'(ETH_HDR_LEN)) ictype_in = req_rx_byte;
               // Checksum fields count as zero while the sums build up.
               if (wc_ff >= CW'(ETH_HDR_LEN) && wc_ff < CW'(hdr_end)) begin
                  if (wc_ff != CW'(24) && wc_ff != CW'(25)) ipsum_in = oc_add(ipsum_in, word);
               end else if (wc_ff >= CW'(hdr_end)) begin
                  if (wc_ff != CW'(hdr_end) && wc_ff != CW'(hdr_end) + CW'(2)
                      && wc_ff != CW'(hdr_end) + CW'(3)) begin
                     icsum_in = oc_add(icsum_in, word);
                  end
               end
            end else begin
               ovf_in = 1'b1;
            end
            if (req_rx_last) begin
               kind_in = KIND_IGNORED;
               plen_in = '0;
               ri_in   = '0;
               if (ovf_in) begin
                  kind_in = KIND_NONE;
               end else if (wc_in >= CW'(ETH_HDR_LEN)) begin
                  if (etype_in == ETHERTYPE_ARP) begin
                     if (wc_in >= CW'(ARP_MIN_LEN) && op_in == ARP_OP_REQUEST
                         && tpa_in == own_ip_ff) begin
                        kind_in = KIND_ARP;
                        plen_in = CW'(ARP_REPLY_LEN);
                     end
                  end else if (etype_in == ETHERTYPE_IPV4 && wc_in >= CW'(ICMP_MIN_LEN)
                               && proto_in == IP_PROTO_ICMP && ihl_in >= IHL_MIN
                               && wc_in >= CW'(ETH_HDR_LEN + 4) + CW'({ihl_in, 2'b00})
                               && ictype_in == ICMP_ECHO_REQUEST && ipdst_in == own_ip_ff) begin
                     kind_in = KIND_ECHO;
                     plen_in = wc_in;
                     hb_in   = {ihl_in, 2'b00};
                     ck_in   = {~ipsum_in, ~icsum_in};
                  end
               end
               wc_in = '0;
            end
         end else if ((kind_ff == KIND_ARP || kind_ff == KIND_ECHO) && ri_ff < plen_ff) begin
            push_cmd.mem_read = rd_mem;
            push_cmd.tx_const = rd_mem ? 8'h00 : rd_const;
            push_addr         = rd_addr[AW-1:0];
            ri_in             = ri_ff + CW'(1);
            if (ri_in == plen_ff) begin
               push_cmd.tx_last = 1'b1;
               kind_in          = KIND_NONE;
               plen_in          = '0;
               ri_in            = '0;
            end
         end
         if (ovf_in && wc_in == '0) begin
            status = STATUS_TOO_LONG;
         end else if (wc_in != '0) begin
            status = STATUS_NONE;
         end else begin
            unique case (kind_in)
               KIND_ARP:     status = STATUS_ARP;
               KIND_ECHO:    status = STATUS_ECHO;
               KIND_IGNORED: status = STATUS_IGNORED;
               default:      status = STATUS_NONE;
            endcase
         end
         push_cmd.status = status;
         push_cmd.length = LEN_W'(plen_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= MAC_W'(48'd17665778743159);
         own_ip_ff  <= 32'd3232235976;
      end else if (csr_write_en) begin
         if (csr_index == CSR_OWN_MAC) own_mac_ff <= csr_write_data[MAC_W-1:0];
         if (csr_index == CSR_OWN_IP)  own_ip_ff  <= csr_write_data[IP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff    <= '0;
         ri_ff    <= '0;
         plen_ff  <= '0;
         kind_ff  <= KIND_NONE;
         hb_ff    <= '0;
         ck_ff    <= '0;
         ovf_ff   <= 1'b0;
         ipsum_ff <= '0;
         icsum_ff <= '0;
      end else begin
         wc_ff    <= wc_in;
         ri_ff    <= ri_in;
         plen_ff  <= plen_in;
         kind_ff  <= kind_in;
         hb_ff    <= hb_in;
         ck_ff    <= ck_in;
         ovf_ff   <= ovf_in;
         ipsum_ff <= ipsum_in;
         icsum_ff <= icsum_in;
      end
   end

   always_ff @(posedge clock) begin
      etype_ff  <= etype_in;
      op_ff     <= op_in;
      proto_ff  <= proto_in;
      ihl_ff    <= ihl_in;
      ipdst_ff  <= ipdst_in;
      tpa_ff    <= tpa_in;
      ictype_ff <= ictype_in;
   end

   a_arp_len : assert property (@(posedge clock) disable iff (reset)
      kind_ff == KIND_ARP |-> plen_ff == CW'(ARP_REPLY_LEN))
      else $error("ARP reply pending with wrong length");

   a_read_in_range : assert property (@(posedge clock) disable iff (reset)
      (kind_ff == KIND_ARP || kind_ff == KIND_ECHO) |-> ri_ff < plen_ff)
      else $error("read index beyond pending reply");

   a_receiving_clears : assert property (@(posedge clock) disable iff (reset)
      wc_ff != '0 |-> kind_ff == KIND_NONE)
      else $error("reply still pending while a frame is received");

   a_echo_header : assert property (@(posedge clock) disable iff (reset)
      kind_ff == KIND_ECHO |-> hb_ff >= 6'd20)
      else $error("echo reply with short IP header");

endmodule

/* hdl/arpp_fifo.sv */
module arpp_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = arpp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop_ready,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);
   import arpp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = count_ff == NW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + NW'(1);
      if (do_pop && !do_push) count_in = count_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* hdl/arpp_back.sv */
module arpp_back #(
   parameter int MAX_FRAME = arpp_pkg::MAX_FRAME_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  arpp_pkg::cmd_type                   cmd,
   input  logic [$clog2(MAX_FRAME)-1:0]        addr,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_tx_last,
   output logic [2:0]                          rsp_reply_status,
   output logic [arpp_pkg::LEN_W-1:0]          rsp_reply_length
);
   import arpp_pkg::*;

   logic [7:0] frame_mem [MAX_FRAME];
   logic [7:0] rdata_ff;
   cmd_type    cmd_ff;
   logic       valid_ff;
   logic       take;

   assign pop_ready = !valid_ff || !rsp_stall;
   assign take      = pop_ready && pop_valid;

   always_ff @(posedge clock) begin
      if (take && cmd.mem_write) frame_mem[addr] <= cmd.wdata;
      if (take && cmd.mem_read)  rdata_ff <= frame_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (take) cmd_ff <= cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_tx_byte      = cmd_ff.mem_read ? rdata_ff : cmd_ff.tx_const;
   assign rsp_tx_last      = cmd_ff.tx_last;
   assign rsp_reply_status = cmd_ff.status;
   assign rsp_reply_length = cmd_ff.length;

endmodule

/* hdl/arp_and_ping_responder_top.sv */
// A result is registered in the queue and then in the back's output register; a stall holds it there.
// Throughput: one item per cycle while req_stall is low; the front classifies and the back owns the frame memory port.
// Checksums accumulate as frame bytes arrive, so classification finishes on the last byte.
// Reset is synchronous and active high; it clears control state and loads the default addresses.
// The frame memory needs no clearing pass: replies only read bytes of the current frame.
module arp_and_ping_responder_top #(
   parameter int MAX_FRAME = arpp_pkg::MAX_FRAME_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_rx_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_tx_byte,
   output logic                          rsp_tx_last,
   output logic [2:0]                    rsp_reply_status,
   output logic [arpp_pkg::LEN_W-1:0]    rsp_reply_length,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [arpp_pkg::CSR_W-1:0]    csr_write_data
);
   import arpp_pkg::*;

   localparam int AW  = $clog2(MAX_FRAME);
   localparam int QW  = $bits(cmd_type) + AW;

   // The front turns every transfer into one operation: a memory write for a
   // stored frame byte, or a memory read or constant byte for a reply byte, together
   // with the status and length that the result reports.
   logic              push_valid;
   cmd_type           push_cmd;
   logic [AW-1:0]     push_addr;
   logic              queue_full;

   // The queue decouples classification from the memory access, so the input
   // keeps taking transfers while a finished result waits at the output, until the queue fills.
   logic              pop_valid;
   logic              pop_ready;
   logic [QW-1:0]     pop_data;
   cmd_type           pop_cmd;
   logic [AW-1:0]     pop_addr;

   arpp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_rx_byte    (req_rx_byte),
      .req_rx_last    (req_rx_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd),
      .push_addr      (push_addr)
   );

   arpp_fifo #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_cmd, push_addr}),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   assign pop_cmd  = pop_data[QW-1:AW];
   assign pop_addr = pop_data[AW-1:0];

   // The back performs the memory access and holds the output register.
   arpp_back #(.MAX_FRAME(MAX_FRAME)) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .cmd              (pop_cmd),
      .addr             (pop_addr),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_last      (rsp_tx_last),
      .rsp_reply_status (rsp_reply_status),
      .rsp_reply_length (rsp_reply_length)
   );

endmodule
